// ===== hw/rtl/clock_replacement_slot_manager_assert.svh =====
// Assertion macros shared by the slot manager RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the user.
`ifndef CLOCK_REPLACEMENT_SLOT_MANAGER_ASSERT_SVH
`define CLOCK_REPLACEMENT_SLOT_MANAGER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CRSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define CRSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/crsm_pkg.sv =====
// Package of the clock replacement slot manager: field widths, codes and state type.
// Has no dependencies; used by clock_replacement_slot_manager.sv.
package crsm_pkg;

  localparam int ReqW    = 3;
  localparam int PSlotW  = 8;
  localparam int RowW    = 31;
  localparam int StatusW = 2;
  localparam int CfgW    = 9;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_FIND   = 3'd0;
  localparam logic [ReqW-1:0] REQ_EVICT  = 3'd1;
  localparam logic [ReqW-1:0] REQ_KEEP   = 3'd2;
  localparam logic [ReqW-1:0] REQ_INSERT = 3'd3;
  localparam logic [ReqW-1:0] REQ_REF    = 3'd4;
  localparam logic [ReqW-1:0] REQ_HAS    = 3'd5;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_ROW  = 7'b0001000,
    S_HAS  = 7'b0010000,
    S_POP  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/crsm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Has no dependencies.
module crsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/clock_replacement_slot_manager.sv =====
// Top level of the clock (second-chance) replacement slot manager.
// Depends on crsm_pkg, crsm_ram and clock_replacement_slot_manager_assert.svh.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ------------------------------------------
//   input     in_valid_i / in_stall_o   req_type_i, slot_i, row_id_i
//   output    out_valid_o / out_stall_i status_o, out_slot_o, out_row_id_o, hit_o
//   config    cfg_we_i                  cfg_wdata_i (capacity)
//
// Evict, keep, reference, refused requests and inserts from never-used slots
// pass through the execute and emit steps; has-row and inserts that reuse a freed
// slot add a read step, since the row table or the free FIFO is read through a
// registered memory port. A victim search adds a scan in which the clock hand
// visits one slot per cycle, then a row read; it gives up after ROUNDS turns.
// Reset leaves every slot stale and empty, the hand at slot 0 and capacity at 256;
// no clearing pass is needed. A stalled output holds the finished item in the
// output register; the next item is still accepted and waits in its final step.
module clock_replacement_slot_manager #(
  parameter int SLOTS  = 256,
  parameter int ROUNDS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: the capacity register.
  input  logic                         cfg_we_i,
  input  logic [crsm_pkg::CfgW-1:0]    cfg_wdata_i,
  // Request items.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [crsm_pkg::ReqW-1:0]    req_type_i,
  input  logic [crsm_pkg::PSlotW-1:0]  slot_i,
  input  logic [crsm_pkg::RowW-1:0]    row_id_i,
  // Result items.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [crsm_pkg::StatusW-1:0] status_o,
  output logic [crsm_pkg::PSlotW-1:0]  out_slot_o,
  output logic [crsm_pkg::RowW-1:0]    out_row_id_o,
  output logic                         hit_o
);

  `include "clock_replacement_slot_manager_assert.svh"

  // Slot index width, count width (holds SLOTS itself), and a compare width wide
  // enough for both the configured capacity and the slot field.
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int XW    = (CW > crsm_pkg::CfgW) ? CW : crsm_pkg::CfgW;
  localparam int StepW = CW + $clog2(ROUNDS + 1);

  // Sequencer and latched request.
  crsm_pkg::state_e state_q, state_d;
  logic [crsm_pkg::ReqW-1:0]   req_q;
  logic [crsm_pkg::PSlotW-1:0] slot_q;
  logic [crsm_pkg::RowW-1:0]   row_q;
  logic                        in_accept;

  // Table state.
  logic [crsm_pkg::CfgW-1:0] cap_q;
  logic [SLOTS-1:0]          stale_q;
  logic [SLOTS-1:0]          occ_q;
  logic [SW-1:0]             hand_q, hand_d;
  logic [CW-1:0]             fresh_q, fresh_d;
  logic [SW-1:0]             head_q, head_d;
  logic [SW-1:0]             tail_q, tail_d;
  logic [CW-1:0]             level_q, level_d;
  logic                      pend_q, pend_d;
  logic [SW-1:0]             pslot_q, pslot_d;
  logic [StepW-1:0]          step_q, step_d;

  // Bit-table writes, one of each per cycle.
  logic          stale_we, stale_val;
  logic [SW-1:0] stale_idx;
  logic          occ_we, occ_val;
  logic [SW-1:0] occ_idx;

  // Insert commit shared by the fresh-slot and free-FIFO paths.
  logic          ins_go;
  logic [SW-1:0] ins_slot;

  // Memories.
  logic                      row_we;
  logic [SW-1:0]             row_waddr, row_raddr;
  logic [crsm_pkg::RowW-1:0] row_rdata;
  logic                      fifo_we;
  logic [SW-1:0]             fifo_raddr;
  logic [SW-1:0]             fifo_rdata;

  // Result held between the last working step and the output register.
  crsm_pkg::status_e           res_status_q, res_status_d;
  logic [crsm_pkg::PSlotW-1:0] res_slot_q, res_slot_d;
  logic [crsm_pkg::RowW-1:0]   res_row_q, res_row_d;
  logic                        res_hit_q, res_hit_d;

  // Output register.
  logic                        out_valid_q;
  logic                        out_load;
  crsm_pkg::status_e           out_status_q;
  logic [crsm_pkg::PSlotW-1:0] out_slot_q;
  logic [crsm_pkg::RowW-1:0]   out_row_q;
  logic                        out_hit_q;

  // Effective capacity: zero acts as one, anything above SLOTS acts as SLOTS.
  logic [XW-1:0]    cap_x, eff_x;
  logic [CW-1:0]    eff_cap;
  logic [XW-1:0]    slot_x, hand_x, hand_nx;
  logic             slot_ok;
  logic [SW-1:0]    slot_idx;
  logic [SW-1:0]    hand_start, hand_next;
  logic [StepW-1:0] steps_total;

  assign cap_x   = XW'(cap_q);
  assign eff_x   = (cap_x == '0) ? XW'(1) :
                   (cap_x > XW'(SLOTS)) ? XW'(SLOTS) : cap_x;
  assign eff_cap = CW'(eff_x);

  assign slot_x   = XW'(slot_q);
  assign slot_ok  = slot_x < eff_x;
  assign slot_idx = SW'(slot_x);

  assign hand_x     = XW'(hand_q);
  assign hand_nx    = hand_x + XW'(1);
  assign hand_start = (hand_x >= eff_x) ? '0 : hand_q;
  assign hand_next  = (hand_nx >= eff_x) ? '0 : SW'(hand_nx);

  // The search gives up after ROUNDS full turns of the hand.
  assign steps_total = StepW'(ROUNDS) * StepW'(eff_cap);

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != crsm_pkg::S_IDLE);

  always_comb begin
    state_d      = state_q;
    hand_d       = hand_q;
    fresh_d      = fresh_q;
    head_d       = head_q;
    tail_d       = tail_q;
    level_d      = level_q;
    pend_d       = pend_q;
    pslot_d      = pslot_q;
    step_d       = step_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_row_d    = res_row_q;
    res_hit_d    = res_hit_q;
    stale_we     = 1'b0;
    stale_val    = 1'b0;
    stale_idx    = slot_idx;
    occ_we       = 1'b0;
    occ_val      = 1'b0;
    occ_idx      = slot_idx;
    ins_go       = 1'b0;
    ins_slot     = fifo_rdata;
    row_raddr    = slot_idx;
    fifo_raddr   = head_q;
    fifo_we      = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      crsm_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = crsm_pkg::S_EXEC;
        end
      end

      crsm_pkg::S_EXEC: begin
        res_status_d = crsm_pkg::ST_OK;
        res_slot_d   = '0;
        res_row_d    = '0;
        res_hit_d    = 1'b0;
        state_d      = crsm_pkg::S_EMIT;
        unique case (req_q)
          crsm_pkg::REQ_FIND: begin
            if (pend_q) begin
              res_status_d = crsm_pkg::ST_REFUSED;
            end else begin
              hand_d  = hand_start;
              step_d  = '0;
              state_d = crsm_pkg::S_SCAN;
            end
          end
          crsm_pkg::REQ_EVICT, crsm_pkg::REQ_KEEP: begin
            if (!slot_ok || !pend_q || slot_idx != pslot_q) begin
              res_status_d = crsm_pkg::ST_REFUSED;
            end else begin
              pend_d = 1'b0;
              if (req_q == crsm_pkg::REQ_EVICT) begin
                occ_we  = 1'b1;
                occ_val = 1'b0;
                if (level_q < CW'(SLOTS)) begin
                  fifo_we = 1'b1;
                  tail_d  = (tail_q == SW'(SLOTS - 1)) ? '0 : tail_q + SW'(1);
                  level_d = level_q + CW'(1);
                end
              end
            end
          end
          crsm_pkg::REQ_INSERT: begin
            if (level_q != '0) begin
              // Reuse a freed slot; its number arrives from the FIFO next cycle.
              head_d  = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + SW'(1);
              level_d = level_q - CW'(1);
              state_d = crsm_pkg::S_POP;
            end else if (fresh_q < eff_cap) begin
              ins_go   = 1'b1;
              ins_slot = SW'(fresh_q);
              fresh_d  = fresh_q + CW'(1);
            end else begin
              res_status_d = crsm_pkg::ST_FULL;
            end
          end
          crsm_pkg::REQ_REF: begin
            if (!slot_ok) begin
              res_status_d = crsm_pkg::ST_REFUSED;
            end else begin
              stale_we  = 1'b1;
              stale_val = 1'b0;
            end
          end
          crsm_pkg::REQ_HAS: begin
            if (!slot_ok) begin
              res_status_d = crsm_pkg::ST_REFUSED;
            end else begin
              state_d = crsm_pkg::S_HAS;
            end
          end
          default: begin
            res_status_d = crsm_pkg::ST_REFUSED;
          end
        endcase
      end

      crsm_pkg::S_SCAN: begin
        if (step_q == steps_total) begin
          res_status_d = crsm_pkg::ST_NONE;
          state_d      = crsm_pkg::S_EMIT;
        end else begin
          step_d = step_q + StepW'(1);
          hand_d = hand_next;
          if (!stale_q[hand_q]) begin
            // Second chance: a recent slot is aged and passed over.
            stale_we  = 1'b1;
            stale_val = 1'b1;
            stale_idx = hand_q;
          end else if (occ_q[hand_q]) begin
            pend_d    = 1'b1;
            pslot_d   = hand_q;
            row_raddr = hand_q;
            state_d   = crsm_pkg::S_ROW;
          end
        end
      end

      crsm_pkg::S_ROW: begin
        res_status_d = crsm_pkg::ST_OK;
        res_slot_d   = crsm_pkg::PSlotW'(XW'(pslot_q));
        res_row_d    = row_rdata;
        state_d      = crsm_pkg::S_EMIT;
      end

      crsm_pkg::S_HAS: begin
        res_hit_d = occ_q[slot_idx] && (row_rdata == row_q);
        state_d   = crsm_pkg::S_EMIT;
      end

      crsm_pkg::S_POP: begin
        ins_go   = 1'b1;
        ins_slot = fifo_rdata;
        state_d  = crsm_pkg::S_EMIT;
      end

      crsm_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = crsm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = crsm_pkg::S_IDLE;
      end
    endcase

    // A new row makes its slot occupied and recent.
    if (ins_go) begin
      stale_we   = 1'b1;
      stale_val  = 1'b0;
      stale_idx  = ins_slot;
      occ_we     = 1'b1;
      occ_val    = 1'b1;
      occ_idx    = ins_slot;
      res_slot_d = crsm_pkg::PSlotW'(XW'(ins_slot));
    end
  end

  assign row_we    = ins_go;
  assign row_waddr = ins_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crsm_pkg::S_IDLE;
      cap_q       <= crsm_pkg::CfgW'(256);
      stale_q     <= '1;
      occ_q       <= '0;
      hand_q      <= '0;
      fresh_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      level_q     <= '0;
      pend_q      <= 1'b0;
      pslot_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (stale_we) begin
        stale_q[stale_idx] <= stale_val;
      end
      if (occ_we) begin
        occ_q[occ_idx] <= occ_val;
      end
      hand_q  <= hand_d;
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
      pend_q  <= pend_d;
      pslot_q <= pslot_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= req_type_i;
      slot_q <= slot_i;
      row_q  <= row_id_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_row_q    <= res_row_d;
    res_hit_q    <= res_hit_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_row_q    <= res_row_q;
      out_hit_q    <= res_hit_q;
    end
  end

  crsm_ram #(
    .Width (crsm_pkg::RowW),
    .Depth (SLOTS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_q),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  crsm_ram #(
    .Width (SW),
    .Depth (SLOTS)
  ) u_free_fifo (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail_q),
    .wdata_i (slot_idx),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_row_id_o = out_row_q;
  assign hit_o        = out_hit_q;

  // Every freed slot was once handed out fresh, so the free list never outgrows it.
  `CRSM_ASSERT(a_free_le_fresh, level_q <= fresh_q, "free list larger than slots used")
  // The pending victim stays occupied until it is evicted or kept.
  `CRSM_ASSERT(a_pend_occupied, pend_q |-> occ_q[pslot_q], "pending victim slot is empty")
  // A result only appears from the final step of the sequencer.
  `CRSM_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q == crsm_pkg::S_EMIT),
    "result appeared outside the emit step")
  // A memory read step always hands over to the emit step.
  `CRSM_ASSERT_NEXT(a_read_to_emit,
    state_q == crsm_pkg::S_ROW || state_q == crsm_pkg::S_HAS || state_q == crsm_pkg::S_POP,
    state_q == crsm_pkg::S_EMIT, "memory read step not followed by emit")

endmodule
